@@ rtl/core/sst_pkg.sv @@
package sst_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam int unsigned KEY_FIELD_W = 32;
  localparam int unsigned POS_FIELD_W = 5;

  typedef struct packed {
    logic [1:0]             mode;
    logic [KEY_FIELD_W-1:0] key;
  } sst_in_t;

  typedef struct packed {
    logic                   found;
    logic [POS_FIELD_W-1:0] position;
    logic [POS_FIELD_W-1:0] count;
    logic                   status;
  } sst_out_t;

  // Commands that the controller broadcasts to every cell of the row.
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } sst_cell_ctl_t;

endpackage

@@ rtl/core/sst_cell.sv @@
module sst_cell #(
  parameter int unsigned KEY_WIDTH = 32,
  parameter int unsigned CW        = 5,
  parameter int unsigned IDX       = 0
) (
  input  logic                  clk,
  input  sst_pkg::sst_cell_ctl_t ctl,
  input  logic [CW-1:0]         pos,
  input  logic                  signed_keys,
  input  logic [KEY_WIDTH-1:0]  op_key,
  input  logic [KEY_WIDTH-1:0]  left_key,
  input  logic [KEY_WIDTH-1:0]  right_key,
  output logic [KEY_WIDTH-1:0]  key_o,
  output logic                  eq_o,
  output logic                  gt_o
);

  localparam logic [CW-1:0]        MY_IDX = CW'(IDX);
  localparam logic [KEY_WIDTH-1:0] TOP    = {1'b1, {(KEY_WIDTH-1){1'b0}}};

  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic                 eq_r, eq_nxt;
  logic                 gt_r, gt_nxt;
  logic [KEY_WIDTH-1:0] flip;
  logic [KEY_WIDTH-1:0] own_ord;
  logic [KEY_WIDTH-1:0] op_ord;

  // Flipping the top bit turns two's complement order into unsigned order.
  assign flip    = signed_keys ? TOP : '0;
  assign own_ord = key_r ^ flip;
  assign op_ord  = op_key ^ flip;

  always_comb begin
    key_nxt = key_r;
    eq_nxt  = eq_r;
    gt_nxt  = gt_r;
    if (ctl.cmp_en) begin
      eq_nxt = (own_ord == op_ord);
      gt_nxt = (own_ord > op_ord);
    end
    if (ctl.ins_en) begin
      if (MY_IDX == pos) begin
        key_nxt = op_key;
      end else if (MY_IDX > pos) begin
        key_nxt = left_key;
      end
    end else if (ctl.del_en) begin
      if (MY_IDX >= pos) begin
        key_nxt = right_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    eq_r  <= eq_nxt;
    gt_r  <= gt_nxt;
  end

  assign key_o = key_r;
  assign eq_o  = eq_r;
  assign gt_o  = gt_r;

endmodule

@@ rtl/core/sorted_set_table_core.sv @@
// Sorted set table: keeps up to CAPACITY distinct keys in ascending order.
// Input channel: an operation (insert, query or remove) and a key are taken
// at a clock edge where start is high and busy is low. busy stays high while
// the operation runs and drops in the cycle the result appears.
// Result channel: out_valid is high for exactly one cycle with found,
// position, count and status; the receiver cannot stall it.
// Configuration: cfg_data selects signed key order and is taken when
// cfg_valid and cfg_ready are high; cfg_ready is high whenever the block is
// idle. Changing the order does not re-sort keys already stored.
// Sequence: a compare step in which every cell compares its key with the
// operation key, then the binary search, one probe per cycle. An insert of
// a new key then scans the cell flags one per cycle, and the shift happens
// in the last scan step. The result strobe follows in the next cycle, and a
// new item can be accepted in that same cycle.
// Reset: the table is emptied and signed order is cleared; no results are
// pending after reset.
module sorted_set_table_core #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sst_pkg::sst_in_t  in_item,
  output logic              out_valid,
  output sst_pkg::sst_out_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned PW = sst_pkg::POS_FIELD_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_SRCH = 4'b0100,
    S_SCAN = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [1:0]            mode_r, mode_nxt;
  logic [KEY_WIDTH-1:0]  key_r, key_nxt;
  logic                  signed_r, signed_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         lo_r, lo_nxt;
  logic [CW-1:0]         hi_r, hi_nxt;
  logic [CW-1:0]         scan_r, scan_nxt;
  logic                  out_valid_r, out_valid_nxt;
  sst_pkg::sst_out_t     out_item_r, out_item_nxt;

  sst_pkg::sst_cell_ctl_t cell_ctl;
  logic [CW-1:0]          cell_pos;
  logic [KEY_WIDTH-1:0]   cell_key [CAPACITY];
  logic [CAPACITY-1:0]    eq_vec;
  logic [CAPACITY-1:0]    gt_vec;

  logic [KEY_WIDTH+KEY_WIDTH+31:0] key_wide;
  logic [CW-1:0]                   mid;
  logic                            search_open;
  logic                            fin;
  logic                            fin_hit;
  logic [CW-1:0]                   fin_pos;
  logic                            fin_status;
  logic [CW+PW-1:0]                pos_wide;
  logic [CW+PW-1:0]                cnt_wide;

  assign key_wide    = {{(KEY_WIDTH+KEY_WIDTH){1'b0}}, in_item.key};
  assign search_open = lo_r < hi_r;
  assign mid         = lo_r + ((hi_r - lo_r) >> 1);
  assign pos_wide    = {{PW{1'b0}}, fin_pos};
  assign cnt_wide    = {{PW{1'b0}}, count_nxt};

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [KEY_WIDTH-1:0] left_k;
      logic [KEY_WIDTH-1:0] right_k;
      if (gi == 0) begin : g_first
        assign left_k = cell_key[gi];
      end else begin : g_left
        assign left_k = cell_key[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_k = cell_key[gi];
      end else begin : g_right
        assign right_k = cell_key[gi+1];
      end
      sst_cell #(
        .KEY_WIDTH (KEY_WIDTH),
        .CW        (CW),
        .IDX       (gi)
      ) u_cell (
        .clk         (clk),
        .ctl         (cell_ctl),
        .pos         (cell_pos),
        .signed_keys (signed_r),
        .op_key      (key_r),
        .left_key    (left_k),
        .right_key   (right_k),
        .key_o       (cell_key[gi]),
        .eq_o        (eq_vec[gi]),
        .gt_o        (gt_vec[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    signed_nxt    = signed_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    scan_nxt      = scan_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    cell_ctl      = '0;
    cell_pos      = '0;
    fin           = 1'b0;
    fin_hit       = 1'b0;
    fin_pos       = '0;
    fin_status    = sst_pkg::STATUS_DONE;

    if (cfg_valid && cfg_ready) begin
      signed_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt  = in_item.mode;
          key_nxt   = key_wide[KEY_WIDTH-1:0];
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cell_ctl.cmp_en = 1'b1;
        lo_nxt          = '0;
        hi_nxt          = count_r;
        state_nxt       = S_SRCH;
      end
      S_SRCH: begin
        if (search_open && !eq_vec[mid[IW-1:0]]) begin
          if (gt_vec[mid[IW-1:0]]) begin
            hi_nxt = mid;
          end else begin
            lo_nxt = mid + CW'(1);
          end
        end else begin
          fin_hit = search_open;
          fin_pos = search_open ? mid : '0;
          if (mode_r == sst_pkg::MODE_INSERT && !fin_hit) begin
            if (count_r >= CW'(CAPACITY)) begin
              fin_status = sst_pkg::STATUS_FULL;
              fin        = 1'b1;
            end else begin
              scan_nxt  = '0;
              state_nxt = S_SCAN;
            end
          end else begin
            if (mode_r == sst_pkg::MODE_REMOVE && fin_hit) begin
              cell_ctl.del_en = 1'b1;
              cell_pos        = mid;
              count_nxt       = count_r - CW'(1);
            end
            fin = 1'b1;
          end
        end
      end
      S_SCAN: begin
        // The insert goes before the first stored key that compares greater.
        if (scan_r < count_r && !gt_vec[scan_r[IW-1:0]]) begin
          scan_nxt = scan_r + CW'(1);
        end else begin
          cell_ctl.ins_en = 1'b1;
          cell_pos        = scan_r;
          count_nxt       = count_r + CW'(1);
          fin_pos         = scan_r;
          fin             = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt             = S_IDLE;
      out_valid_nxt         = 1'b1;
      out_item_nxt.found    = fin_hit;
      out_item_nxt.position = pos_wide[PW-1:0];
      out_item_nxt.count    = cnt_wide[PW-1:0];
      out_item_nxt.status   = fin_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      signed_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      signed_r    <= signed_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    scan_r     <= scan_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/core/sst_checker.sv @@
module sst_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input sst_pkg::sst_out_t out_item
);

  // Every operation needs at least the compare and search cycles.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted beat");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("operation ended without a result beat");

  a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == sst_pkg::STATUS_FULL) |->
      (!out_item.found && out_item.position == '0))
    else $error("refused insert reported a hit or a position");

endmodule

bind sorted_set_table_core sst_checker u_sst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

@@ test/sorted_set_table_core_tb.sv @@
module sorted_set_table_core_tb;
  import sst_pkg::*;

  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned KEY_WIDTH = 32;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  sst_in_t  in_item;
  logic     out_valid;
  sst_out_t out_item;
  logic     cfg_valid;
  logic     cfg_ready;
  logic     cfg_data;

  // Shadow copy of the table, the ordering rule and the results still owed.
  logic [KEY_WIDTH-1:0] tbl_keys [CAPACITY];
  int unsigned          tbl_count;
  bit                   order_signed;
  sst_out_t             owed_results [$];
  int unsigned          mismatch_count;
  int unsigned          stall_cycles;

  sorted_set_table_core #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // True when key a sorts after key b under the current rule.
  function automatic bit sorts_after(logic [KEY_WIDTH-1:0] a, logic [KEY_WIDTH-1:0] b);
    logic [KEY_WIDTH-1:0] x;
    logic [KEY_WIDTH-1:0] y;
    x = a;
    y = b;
    if (order_signed) begin
      x[KEY_WIDTH-1] = ~x[KEY_WIDTH-1];
      y[KEY_WIDTH-1] = ~y[KEY_WIDTH-1];
    end
    return x > y;
  endfunction

  // Applies one operation to the shadow table and returns the result it owes.
  function automatic sst_out_t table_apply(sst_in_t op);
    sst_out_t    res;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned where;
    int unsigned i;
    bit          hit;
    logic        status;
    lo = 0;
    hi = tbl_count;
    hit = 1'b0;
    where = 0;
    status = STATUS_DONE;
    // The search runs on the stored order even if the rule changed since.
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (tbl_keys[mid] == op.key) begin
        hit = 1'b1;
        where = mid;
        break;
      end
      if (sorts_after(tbl_keys[mid], op.key)) hi = mid;
      else lo = mid + 1;
    end
    if (op.mode == MODE_INSERT && !hit) begin
      where = 0;
      if (tbl_count >= CAPACITY) begin
        status = STATUS_FULL;
      end else begin
        while (where < tbl_count && !sorts_after(tbl_keys[where], op.key)) where++;
        for (i = tbl_count; i > where; i--) tbl_keys[i] = tbl_keys[i-1];
        tbl_keys[where] = op.key;
        tbl_count++;
      end
    end else if (op.mode == MODE_REMOVE && hit) begin
      for (i = where; i + 1 < tbl_count; i++) tbl_keys[i] = tbl_keys[i+1];
      tbl_count--;
    end
    res.found    = hit;
    res.position = where[POS_FIELD_W-1:0];
    res.count    = tbl_count[POS_FIELD_W-1:0];
    res.status   = status;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_op(input logic [1:0] mode, input logic [KEY_WIDTH-1:0] key);
    sst_in_t op;
    op.mode = mode;
    op.key  = key;
    in_item = op;
    start   = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    owed_results.push_back(table_apply(op));
    @(negedge clk);
  endtask

  task automatic idle_cycles(input int unsigned n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_order(input logic use_signed);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data  = use_signed;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    order_signed = use_signed;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_basic_ops();
    send_op(MODE_QUERY, 32'd5);
    send_op(MODE_REMOVE, 32'd5);
    send_op(MODE_INSERT, 32'h1234_5678);
    send_op(MODE_INSERT, 32'h0000_0000);
    send_op(MODE_INSERT, 32'hFFFF_FFFF);
    send_op(MODE_INSERT, 32'h0000_0000);
    send_op(MODE_QUERY, 32'h0000_0000);
    send_op(MODE_QUERY, 32'hFFFF_FFFF);
    send_op(MODE_UNUSED, 32'h1234_5678);
    send_op(MODE_UNUSED, 32'hAAAA_AAAA);
    send_op(MODE_REMOVE, 32'h1234_5678);
    send_op(MODE_REMOVE, 32'h1234_5678);
    send_op(MODE_INSERT, 32'h1234_5678);
  endtask

  // Switches to signed order with unsigned-sorted keys still in the table.
  task automatic test_signed_order();
    write_order(1'b1);
    send_op(MODE_QUERY, 32'hFFFF_FFFF);
    send_op(MODE_INSERT, 32'h8000_0000);
    send_op(MODE_INSERT, 32'h7FFF_FFFF);
    send_op(MODE_INSERT, 32'hFFFF_FFFE);
    send_op(MODE_QUERY, 32'h8000_0000);
    send_op(MODE_REMOVE, 32'h0000_0000);
    send_op(MODE_QUERY, 32'h5555_5555);
  endtask

  task automatic test_full_table();
    while (tbl_count < CAPACITY) send_op(MODE_INSERT, $urandom);
    send_op(MODE_INSERT, $urandom);
    send_op(MODE_INSERT, tbl_keys[3]);
    send_op(MODE_QUERY, tbl_keys[CAPACITY-1]);
    send_op(MODE_REMOVE, tbl_keys[0]);
    send_op(MODE_INSERT, 32'h0000_0001);
    send_op(MODE_INSERT, 32'h0000_0002);
  endtask

  task automatic test_random_traffic();
    logic [KEY_WIDTH-1:0] pool [24];
    logic [KEY_WIDTH-1:0] key;
    logic [1:0]           mode;
    int unsigned          phase;
    int unsigned          n;
    int unsigned          i;
    int unsigned          burst_left;
    int unsigned          insert_pct;
    int unsigned          remove_pct;
    int unsigned          roll;
    for (phase = 0; phase < 4; phase++) begin
      write_order(phase == 0 ? 1'b0 : phase == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
      // A small pool of keys keeps hits, duplicates and removals common.
      pool[0] = 32'h0000_0000;
      pool[1] = 32'hFFFF_FFFF;
      pool[2] = 32'h8000_0000;
      pool[3] = 32'h7FFF_FFFF;
      for (i = 4; i < 24; i++)
        pool[i] = (i % 3 == 0) ? $urandom_range(0, 40) : $urandom;
      insert_pct = (phase == 2) ? 70 : 45;
      remove_pct = (phase == 3) ? 40 : 25;
      burst_left = 0;
      for (n = 0; n < 200; n++) begin
        if (burst_left == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(20, 40);
          end else begin
            idle_cycles($urandom_range(1, 6));
            burst_left = $urandom_range(1, 10);
          end
        end
        burst_left--;
        if ($urandom_range(0, 49) == 0) wait_drained();
        roll = $urandom_range(0, 99);
        if (roll < insert_pct) mode = MODE_INSERT;
        else if (roll < insert_pct + remove_pct) mode = MODE_REMOVE;
        else if (roll < 97) mode = MODE_QUERY;
        else mode = MODE_UNUSED;
        if (mode == MODE_REMOVE && tbl_count > 0 && $urandom_range(0, 1) == 1)
          key = tbl_keys[$urandom_range(0, tbl_count - 1)];
        else if ($urandom_range(0, 3) == 0)
          key = $urandom;
        else
          key = pool[$urandom_range(0, 23)];
        send_op(mode, key);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    sst_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (owed_results.size() == 0) begin
        report_mismatch("result beat with nothing owed, count", out_item.count, 0);
      end else begin
        want = owed_results.pop_front();
        if (out_item.found !== want.found)
          report_mismatch("found", out_item.found, want.found);
        if (out_item.position !== want.position)
          report_mismatch("position", out_item.position, want.position);
        if (out_item.count !== want.count)
          report_mismatch("count", out_item.count, want.count);
        if (out_item.status !== want.status)
          report_mismatch("status", out_item.status, want.status);
      end
    end
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1 ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_item        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = 1'b0;
    tbl_count      = 0;
    order_signed   = 1'b0;
    mismatch_count = 0;
    stall_cycles   = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_basic_ops();
    test_signed_order();
    test_full_table();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
